@@ rtl/core/lafe_pkg.sv @@
package lafe_pkg;

    // Element and result field widths, and the default list depth
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int POS_W     = 6;
    localparam int SIZE_W    = 7;
    localparam int DEPTH_DEF = 64;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FIND   = 2'd2,
        OP_ERASE  = 2'd3
    } op_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic append;   // write key into the cell at the tail
        logic erase;    // shift selected cells down by one
        logic compare;  // capture the match flag
    } cell_ctrl_t;

endpackage

@@ rtl/core/list_append_find_erase_unit.sv @@
// List of up to DEPTH signed 32-bit values held in a row of cells, one element per cell.
// A request is taken when start is high and busy is low. For clear and append the result
// strobes on done in the next cycle. For find and erase, every cell compares its element in
// the compare state, the first match is picked in the pick state, and the apply state
// reports it and, on erase, moves each later element down one cell. The result is presented
// on done for exactly one cycle and must be captured then; the receiver cannot stall it.
// A new request may be issued in the same cycle that done is high.
module list_append_find_erase_unit
    import lafe_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   op,
    input  logic [DATA_W-1:0] value,
    output logic              done,
    output logic              found,
    output logic [POS_W-1:0]  position,
    output logic [SIZE_W-1:0] size,
    output logic              empty_res,
    output logic              full_error
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_PICK  = 4'b0100,
        ST_APPLY = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] key_reg;
    logic [OP_W-1:0]   op_reg;
    logic              done_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  size_reg;
    logic              ferr_reg;

    logic              accept;
    logic              res_load;
    logic              res_found;
    logic              res_ferr;
    logic [IDX_W-1:0]  res_pos;
    logic [DATA_W-1:0] key_bus;
    cell_ctrl_t        ctrl;

    logic [DEPTH-1:0]  match_vec;
    logic [DEPTH-1:0]  ge_mask;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic              pick_any;
    logic [IDX_W-1:0]  pick_pos;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign key_bus = busy ? key_reg : value;

    // Sequence the request and compute the next count and result
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ctrl         = '0;
        res_load     = 1'b0;
        res_found    = 1'b0;
        res_ferr     = 1'b0;
        res_pos      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            res_load   = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            res_load = 1'b1;
                            if (count_reg >= DEPTH_C)
                            begin
                                res_ferr = 1'b1;
                            end
                            else
                            begin
                                ctrl.append = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            state_next = ST_CMP;
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                ctrl.compare = 1'b1;
                state_next   = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
                if (pick_any)
                begin
                    res_found = 1'b1;
                    res_pos   = pick_pos;
                    if (op_reg == OP_ERASE)
                    begin
                        ctrl.erase = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= res_load;
        end
    end

    // Hold the request and the result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= value;
            op_reg  <= op;
        end
        if (res_load)
        begin
            found_reg <= res_found;
            pos_reg   <= res_pos;
            size_reg  <= count_next;
            ferr_reg  <= res_ferr;
        end
    end

    // Row of cells, each fed by its upper neighbor, the top one by zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] nbr;
        if (i == DEPTH - 1)
        begin : g_top
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end
        lafe_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .key       (key_bus),
            .shift_sel (ge_mask[i]),
            .nbr_data  (nbr),
            .data      (cell_data[i]),
            .match     (match_vec[i])
        );
    end

    lafe_pick #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_pick (
        .clk       (clk),
        .load      (state_reg == ST_PICK),
        .match_vec (match_vec),
        .any       (pick_any),
        .pos       (pick_pos),
        .ge_mask   (ge_mask)
    );

    // Fit index and count to the result field widths
    if (IDX_W >= POS_W)
    begin : g_pos_trunc
        assign position = pos_reg[POS_W-1:0];
    end
    else
    begin : g_pos_ext
        assign position = {{(POS_W-IDX_W){1'b0}}, pos_reg};
    end

    if (CNT_W >= SIZE_W)
    begin : g_size_trunc
        assign size = size_reg[SIZE_W-1:0];
    end
    else
    begin : g_size_ext
        assign size = {{(SIZE_W-CNT_W){1'b0}}, size_reg};
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign empty_res  = (size_reg == '0);
    assign full_error = ferr_reg;

endmodule

@@ rtl/core/lafe_cell.sv @@
module lafe_cell
    import lafe_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]  count,
    input  logic [DATA_W-1:0] key,
    input  logic              shift_sel,
    input  logic [DATA_W-1:0] nbr_data,
    output logic [DATA_W-1:0] data,
    output logic              match
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic              match_reg;

    // Load on append at the tail, take the upper neighbor on erase, flag a match
    always_ff @(posedge clk)
    begin
        if (ctrl.append && (count == IDX_C))
        begin
            data_reg <= key;
        end
        else if (ctrl.erase && shift_sel)
        begin
            data_reg <= nbr_data;
        end
        if (ctrl.compare)
        begin
            match_reg <= (IDX_C < count) && (data_reg == key);
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ rtl/core/lafe_pick.sv @@
module lafe_pick
    import lafe_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              load,
    input  logic [DEPTH-1:0]  match_vec,
    output logic              any,
    output logic [IDX_W-1:0]  pos,
    output logic [DEPTH-1:0]  ge_mask
);

    logic [DEPTH-1:0] first_reg;
    logic [DEPTH-1:0] first_next;
    logic             any_reg;

    // Isolate the lowest set match bit
    assign first_next = match_vec & (~match_vec + DEPTH'(1));

    // Hold the one-hot first match for the apply step
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            first_reg <= first_next;
            any_reg   <= |match_vec;
        end
    end

    // Encode the one-hot pick into an index
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_reg[i])
            begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    // Mark every cell at or above the pick
    assign ge_mask = ~(first_reg - DEPTH'(1));
    assign any     = any_reg;

endmodule
